// ===== rtl/pce_pkg.sv =====
// ---------------------------------------------------------------------------
// pce_pkg: shared types and preset table of the preset CRC engine
// Holds the CRC width codes, the preset descriptor and the lookup of the
// fifteen fixed CRC-8/16/32 presets, plus bit reflection helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

	localparam int unsigned PresetW = 4;
	localparam int unsigned CrcW    = 32;
	localparam int unsigned ByteW   = 8;

	localparam logic [PresetW-1:0] PresetReset = 4'd13;
	localparam logic [PresetW-1:0] PresetMax   = 4'd14;

	// preset indexes
	localparam logic [PresetW-1:0] PrCrc8        = 4'd0;
	localparam logic [PresetW-1:0] PrCrc8Itu     = 4'd1;
	localparam logic [PresetW-1:0] PrCrc8Rohc    = 4'd2;
	localparam logic [PresetW-1:0] PrCrc8Maxim   = 4'd3;
	localparam logic [PresetW-1:0] PrCrc16Ibm    = 4'd4;
	localparam logic [PresetW-1:0] PrCrc16Maxim  = 4'd5;
	localparam logic [PresetW-1:0] PrCrc16Usb    = 4'd6;
	localparam logic [PresetW-1:0] PrCrc16Modbus = 4'd7;
	localparam logic [PresetW-1:0] PrCrc16Ccitt  = 4'd8;
	localparam logic [PresetW-1:0] PrCrc16CcittF = 4'd9;
	localparam logic [PresetW-1:0] PrCrc16X25    = 4'd10;
	localparam logic [PresetW-1:0] PrCrc16Xmodem = 4'd11;
	localparam logic [PresetW-1:0] PrCrc16Dnp    = 4'd12;
	localparam logic [PresetW-1:0] PrCrc32       = 4'd13;
	localparam logic [PresetW-1:0] PrCrc32Mpeg2  = 4'd14;

	typedef enum logic [1:0] {
		WIDTH_8,
		WIDTH_16,
		WIDTH_32
	} width_t;

	typedef struct packed {
		width_t            width;
		logic [CrcW-1:0]   poly;
		logic [CrcW-1:0]   init;
		logic              refin;
		logic              refout;
		logic [CrcW-1:0]   xorout;
	} preset_t;

	function automatic preset_t make_preset(width_t w, logic [CrcW-1:0] poly,
			logic [CrcW-1:0] init, logic refin, logic refout,
			logic [CrcW-1:0] xorout);
		preset_t p;
		p.width  = w;
		p.poly   = poly;
		p.init   = init;
		p.refin  = refin;
		p.refout = refout;
		p.xorout = xorout;
		return p;
	endfunction

	function automatic preset_t preset_lookup(logic [PresetW-1:0] idx);
		preset_t p;
		unique case (idx)
			PrCrc8:        p = make_preset(WIDTH_8, 32'h07, 32'h00, 1'b0, 1'b0, 32'h00);
			PrCrc8Itu:     p = make_preset(WIDTH_8, 32'h07, 32'h00, 1'b0, 1'b0, 32'h55);
			PrCrc8Rohc:    p = make_preset(WIDTH_8, 32'h07, 32'hff, 1'b1, 1'b1, 32'h00);
			PrCrc8Maxim:   p = make_preset(WIDTH_8, 32'h31, 32'h00, 1'b1, 1'b1, 32'h00);
			PrCrc16Ibm:    p = make_preset(WIDTH_16, 32'h8005, 32'h0000, 1'b1, 1'b1, 32'h0000);
			PrCrc16Maxim:  p = make_preset(WIDTH_16, 32'h8005, 32'h0000, 1'b1, 1'b1, 32'hffff);
			PrCrc16Usb:    p = make_preset(WIDTH_16, 32'h8005, 32'hffff, 1'b1, 1'b1, 32'hffff);
			PrCrc16Modbus: p = make_preset(WIDTH_16, 32'h8005, 32'hffff, 1'b1, 1'b1, 32'h0000);
			PrCrc16Ccitt:  p = make_preset(WIDTH_16, 32'h1021, 32'h0000, 1'b1, 1'b1, 32'h0000);
			PrCrc16CcittF: p = make_preset(WIDTH_16, 32'h1021, 32'hffff, 1'b0, 1'b0, 32'h0000);
			PrCrc16X25:    p = make_preset(WIDTH_16, 32'h1021, 32'hffff, 1'b1, 1'b1, 32'hffff);
			PrCrc16Xmodem: p = make_preset(WIDTH_16, 32'h1021, 32'h0000, 1'b0, 1'b0, 32'h0000);
			PrCrc16Dnp:    p = make_preset(WIDTH_16, 32'h3d65, 32'h0000, 1'b1, 1'b1, 32'hffff);
			PrCrc32:       p = make_preset(WIDTH_32, 32'h04c11db7, 32'hffffffff, 1'b1, 1'b1,
					32'hffffffff);
			PrCrc32Mpeg2:  p = make_preset(WIDTH_32, 32'h04c11db7, 32'hffffffff, 1'b0, 1'b0,
					32'h00000000);
			default:       p = make_preset(WIDTH_32, 32'h04c11db7, 32'hffffffff, 1'b1, 1'b1,
					32'hffffffff);
		endcase
		return p;
	endfunction

	function automatic logic [CrcW-1:0] width_mask(width_t w);
		logic [CrcW-1:0] m;
		unique case (w)
			WIDTH_8:  m = 32'h0000_00ff;
			WIDTH_16: m = 32'h0000_ffff;
			WIDTH_32: m = 32'hffff_ffff;
			default:  m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	function automatic logic [ByteW-1:0] reflect8(logic [ByteW-1:0] v);
		logic [ByteW-1:0] r;
		for (int i = 0; i < ByteW; i++) begin
			r[ByteW-1-i] = v[i];
		end
		return r;
	endfunction

	// reflect the low w bits of v, result right-aligned
	function automatic logic [CrcW-1:0] reflect_w(logic [CrcW-1:0] v, width_t w);
		logic [CrcW-1:0] r;
		logic [CrcW-1:0] o;
		for (int i = 0; i < CrcW; i++) begin
			r[CrcW-1-i] = v[i];
		end
		unique case (w)
			WIDTH_8:  o = r >> 24;
			WIDTH_16: o = r >> 16;
			WIDTH_32: o = r;
			default:  o = r;
		endcase
		return o;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pce_crc_update.sv =====
// ---------------------------------------------------------------------------
// pce_crc_update: one-byte CRC update and final CRC formatting
// Loads the initial value on a message start, folds one byte in MSB-first
// (eight unrolled shift steps) and forms the final CRC, reflected if refout is set, then XORed.
// ---------------------------------------------------------------------------
`default_nettype none

module pce_crc_update (
	input  wire pce_pkg::preset_t                 preset,
	input  wire logic                             start,
	input  wire logic [pce_pkg::CrcW-1:0]         rem_in,
	input  wire logic [pce_pkg::ByteW-1:0]        data,
	output logic      [pce_pkg::CrcW-1:0]         rem_out,
	output logic      [pce_pkg::CrcW-1:0]         crc_out
);

	logic [pce_pkg::CrcW-1:0] mask;

	assign mask = pce_pkg::width_mask(preset.width);

	always_comb begin
		logic [pce_pkg::CrcW-1:0]  rem;
		logic [pce_pkg::ByteW-1:0] b;
		logic                      topbit;
		rem = start ? preset.init : rem_in;
		rem = rem & mask;
		b = preset.refin ? pce_pkg::reflect8(data) : data;
		unique case (preset.width)
			pce_pkg::WIDTH_8:  rem = rem ^ {24'b0, b};
			pce_pkg::WIDTH_16: rem = rem ^ {16'b0, b, 8'b0};
			pce_pkg::WIDTH_32: rem = rem ^ {b, 24'b0};
			default:           rem = rem ^ {b, 24'b0};
		endcase
		for (int i = 0; i < pce_pkg::ByteW; i++) begin
			unique case (preset.width)
				pce_pkg::WIDTH_8:  topbit = rem[7];
				pce_pkg::WIDTH_16: topbit = rem[15];
				pce_pkg::WIDTH_32: topbit = rem[31];
				default:           topbit = rem[31];
			endcase
			rem = ((rem << 1) ^ (topbit ? preset.poly : '0)) & mask;
		end
		rem_out = rem;
	end

	always_comb begin
		logic [pce_pkg::CrcW-1:0] c;
		c = preset.refout ? pce_pkg::reflect_w(rem_out, preset.width) : rem_out;
		crc_out = (c ^ preset.xorout) & mask;
	end

endmodule

`default_nettype wire

// ===== rtl/preset_crc_engine.sv =====
// ---------------------------------------------------------------------------
// preset_crc_engine: byte-serial CRC engine with fifteen fixed presets
// Input register, combinational byte update against the running remainder,
// and an output register holding the finished CRC word.
// ---------------------------------------------------------------------------
// Throughput: one byte per cycle; a last byte waits in the input register while
//   the previous CRC word is stalled on the output.
// Path: the last byte is held in the input register, then its CRC word in the
//   output register, which drives out_valid and crc_value.
// The remainder feedback loops from rem_q through the combinational byte update.
// Reset: async, active low; clears valids and message state, preset = CRC-32.
// ---------------------------------------------------------------------------
`default_nettype none

module preset_crc_engine (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              crc_preset_we,
	input  wire logic [pce_pkg::PresetW-1:0]       crc_preset_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [pce_pkg::ByteW-1:0]         data_byte,
	input  wire logic                              last_byte,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [pce_pkg::CrcW-1:0]          crc_value
);

	logic [pce_pkg::PresetW-1:0] preset_q;
	logic                        s1_valid_q;
	logic [pce_pkg::ByteW-1:0]   data_s1;
	logic                        last_s1;
	logic [pce_pkg::CrcW-1:0]    rem_q;
	logic                        in_msg_q;
	logic                        out_valid_q;
	logic [pce_pkg::CrcW-1:0]    crc_q;

	logic                        in_accept;
	logic                        s1_adv;
	logic                        out_space;
	pce_pkg::preset_t            preset;
	logic [pce_pkg::CrcW-1:0]    rem_next;
	logic [pce_pkg::CrcW-1:0]    crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= pce_pkg::PresetReset;
		end else if (crc_preset_we && crc_preset_wdata <= pce_pkg::PresetMax) begin
			preset_q <= crc_preset_wdata;
		end
	end

	assign preset = pce_pkg::preset_lookup(preset_q);

	// a non-last word never needs output space
	assign out_space = !out_valid_q || !out_stall;
	assign s1_adv    = s1_valid_q && (!last_s1 || out_space);
	assign in_stall  = s1_valid_q && !s1_adv;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	pce_crc_update u_update (
		.preset  (preset),
		.start   (!in_msg_q),
		.rem_in  (rem_q),
		.data    (data_s1),
		.rem_out (rem_next),
		.crc_out (crc_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= '0;
			in_msg_q <= 1'b0;
		end else if (s1_adv) begin
			rem_q    <= rem_next;
			in_msg_q <= !last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			crc_q <= crc_next;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_q;

	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_valid_q |-> !in_stall)
		else $error("input stalled with empty input register");

	a_last_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && last_s1 |=> out_valid_q && !in_msg_q)
		else $error("last word did not produce a CRC word");

	a_msg_open: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && !last_s1 |=> in_msg_q)
		else $error("message not marked open after non-last word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(crc_q))
		else $error("pending CRC word overwritten");

	a_preset_legal: assert property (@(posedge clk) disable iff (!arst_n)
		preset_q <= pce_pkg::PresetMax)
		else $error("illegal preset index stored");

endmodule

`default_nettype wire
